/* design/rsd_pkg.sv */
// ----------------------------------------------------------------------------
// Radar segment deframer package
// Shared constants, codes and the result record of the segment deframer.
// ----------------------------------------------------------------------------
package rsd_pkg;

    // Byte position counter, saturating at its maximum.
    localparam int unsigned POS_W = 15;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Segment layout: the length field sits at positions 2 to 5, and the data
    // starts after a seven byte header and a fifteen byte payload preamble.
    localparam int unsigned HDR_SKIP     = 7;
    localparam int unsigned PAYLOAD_SKIP = 15;
    localparam int unsigned DATA_FIRST   = HDR_SKIP + PAYLOAD_SKIP;
    localparam int unsigned LEN_FIRST    = 2;
    localparam int unsigned LEN_LAST     = 5;
    localparam int unsigned MIN_LEN      = 17;

    // Field widths of the channels.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SEG_W    = 3;
    localparam int unsigned OFFSET_W = 14;
    localparam int unsigned REQ_W    = 4;
    localparam int unsigned SPF_W    = 4;

    // Request numbers run from REQ_FIRST to the segment count plus one.
    localparam logic [REQ_W-1:0] REQ_FIRST = 4'd2;

    // Register reset value and parameter defaults.
    localparam logic [SPF_W-1:0] SPF_RESET  = 4'd6;
    localparam int unsigned DEF_MAX_FRAME_BYTES = 16384;
    localparam int unsigned DEF_MAX_SEGMENTS    = 8;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_MISMATCH   = 2'd1,
        STATUS_BAD_LENGTH = 2'd2
    } status_t;

    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    data_byte;
        logic [SEG_W-1:0]     segment;
        logic [OFFSET_W-1:0]  data_offset;
        status_t              status;
        logic                 frame_done;
        logic [REQ_W-1:0]     next_ack_request;
    } result_t;

endpackage

/* design/rsd_if.sv */
// ----------------------------------------------------------------------------
// Radar segment deframer channels
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface rsd_rx_if
    import rsd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              start_of_transfer;
    logic              resync;

    modport source (output valid, output rx_byte, output start_of_transfer,
                    output resync, input ready);
    modport sink   (input valid, input rx_byte, input start_of_transfer,
                    input resync, output ready);
endinterface

interface rsd_result_if
    import rsd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [SEG_W-1:0]    segment;
    logic [OFFSET_W-1:0] data_offset;
    logic [1:0]          status;
    logic                frame_done;
    logic [REQ_W-1:0]    next_ack_request;

    modport source (output valid, output kind, output data_byte, output segment,
                    output data_offset, output status, output frame_done,
                    output next_ack_request, input ready);
    modport sink   (input valid, input kind, input data_byte, input segment,
                    input data_offset, input status, input frame_done,
                    input next_ack_request, output ready);
endinterface

/* design/rsd_tracker.sv */
// ----------------------------------------------------------------------------
// Radar segment deframer tracker
// Segment state registers and the per-byte decode of one transfer.
// ----------------------------------------------------------------------------
module rsd_tracker
    import rsd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int unsigned MAX_SEGMENTS    = DEF_MAX_SEGMENTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              start_of_transfer,
    input  logic              resync,
    input  logic [SPF_W-1:0]  segments_per_frame,
    output logic              emit,
    output result_t           result
);

    // Only lengths whose frame fits the buffer are kept in full; any set bit
    // above that width is folded into a single overflow flag.
    localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [LEN_W:0] FRAME_LIMIT = (LEN_W+1)'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0] len_reg,  len_next;
    logic             len_hi_reg, len_hi_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [SEG_W-1:0] seg_reg,  seg_next;
    logic [REQ_W-1:0] req_reg,  req_next;
    logic             done_reg, done_next;

    logic [SPF_W-1:0] seg_count;
    logic [POS_W-1:0] pos_base;
    logic [SEG_W-1:0] seg_base;
    logic [REQ_W-1:0] req_base;
    logic [REQ_W:0]   req_inc;
    logic [31:0]      len_shift;
    logic [LEN_W:0]   len_plus;
    logic [POS_W-1:0] last_pos;
    logic [SEG_W:0]   seg_inc;
    logic             bad_len;
    logic             count_done;

    always_comb
    begin
        if (segments_per_frame == '0)
        begin
            seg_count = SPF_W'(1);
        end
        else if (segments_per_frame > SPF_W'(MAX_SEGMENTS))
        begin
            seg_count = SPF_W'(MAX_SEGMENTS);
        end
        else
        begin
            seg_count = segments_per_frame;
        end
    end

    always_comb
    begin
        // A start restarts the transfer before the byte itself is decoded.
        pos_base    = start_of_transfer ? '0 : pos_reg;
        len_next    = start_of_transfer ? '0 : len_reg;
        len_hi_next = start_of_transfer ? 1'b0 : len_hi_reg;
        sum_next    = start_of_transfer ? '0 : sum_reg;
        done_next   = start_of_transfer ? 1'b0 : done_reg;
        seg_base    = (start_of_transfer && resync) ? '0 : seg_reg;

        req_base = (start_of_transfer && resync) ? REQ_FIRST : req_reg;
        req_inc  = {1'b0, req_base} + (REQ_W+1)'(1);
        if (!start_of_transfer)
        begin
            req_next = req_base;
        end
        else if (req_inc > ({1'b0, seg_count} + (REQ_W+1)'(1)))
        begin
            req_next = REQ_FIRST;
        end
        else
        begin
            req_next = req_inc[REQ_W-1:0];
        end

        seg_next = seg_base;
        pos_next = pos_base;

        len_shift = 32'(rx_byte) << {pos_base[1:0] - 2'd2, 3'b000};
        len_plus  = {1'b0, len_next | len_shift[LEN_W-1:0]} + (LEN_W+1)'(LEN_LAST);
        bad_len   = len_hi_next || (|len_shift[31:LEN_W])
                    || ((len_next | len_shift[LEN_W-1:0]) < LEN_W'(MIN_LEN))
                    || (len_plus >= FRAME_LIMIT);
        last_pos  = POS_W'(len_next) + POS_W'(LEN_LAST);
        seg_inc   = {1'b0, seg_base} + (SEG_W+1)'(1);
        count_done = (seg_inc >= (SEG_W+1)'(seg_count));

        emit = 1'b0;
        result.kind             = KIND_DATA;
        result.data_byte        = rx_byte;
        result.segment          = seg_base;
        result.data_offset      = OFFSET_W'(pos_base - POS_W'(DATA_FIRST));
        result.status           = STATUS_OK;
        result.frame_done       = 1'b0;
        result.next_ack_request = req_next;

        if (!done_next)
        begin
            if (pos_base != POS_MAX)
            begin
                pos_next = pos_base + POS_W'(1);
            end

            if (pos_base == '0)
            begin
                // The header byte is outside the checksum.
            end
            else if (pos_base <= POS_W'(LEN_LAST))
            begin
                sum_next = sum_next + rx_byte;
                if (pos_base >= POS_W'(LEN_FIRST))
                begin
                    len_next    = len_next | len_shift[LEN_W-1:0];
                    len_hi_next = len_hi_next | (|len_shift[31:LEN_W]);
                end
                if ((pos_base == POS_W'(LEN_LAST)) && bad_len)
                begin
                    emit             = 1'b1;
                    done_next        = 1'b1;
                    result.kind      = KIND_VERDICT;
                    result.status    = STATUS_BAD_LENGTH;
                end
            end
            else if (pos_base < last_pos)
            begin
                sum_next = sum_next + rx_byte;
                emit     = (pos_base >= POS_W'(DATA_FIRST));
            end
            else if (pos_base == last_pos)
            begin
                emit        = 1'b1;
                done_next   = 1'b1;
                result.kind = KIND_VERDICT;
                if (rx_byte == sum_next)
                begin
                    result.frame_done = count_done;
                    seg_next = count_done ? '0 : seg_inc[SEG_W-1:0];
                end
                else
                begin
                    result.status = STATUS_MISMATCH;
                end
            end
        end

        if (result.kind == KIND_VERDICT)
        begin
            result.data_byte   = '0;
            result.data_offset = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            len_hi_reg <= 1'b0;
            sum_reg    <= '0;
            seg_reg    <= '0;
            req_reg    <= REQ_FIRST;
            done_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            len_hi_reg <= len_hi_next;
            sum_reg    <= sum_next;
            seg_reg    <= seg_next;
            req_reg    <= req_next;
            done_reg   <= done_next;
        end
    end

endmodule

/* design/rsd_out_stage.sv */
// ----------------------------------------------------------------------------
// Radar segment deframer result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rsd_out_stage
    import rsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    full,
    rsd_result_if.source res
);

    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign full                 = valid_reg;
    assign res.valid            = valid_reg;
    assign res.kind             = data_reg.kind;
    assign res.data_byte        = data_reg.data_byte;
    assign res.segment          = data_reg.segment;
    assign res.data_offset      = data_reg.data_offset;
    assign res.status           = data_reg.status;
    assign res.frame_done       = data_reg.frame_done;
    assign res.next_ack_request = data_reg.next_ack_request;

endmodule

/* design/radar_segment_deframer_core.sv */
// ----------------------------------------------------------------------------
// Radar segment deframer core
// Splits a received sensor transfer into segment data bytes and a verdict.
// ----------------------------------------------------------------------------
// The core takes one received byte per clock. Each byte is decoded
// combinationally against the segment state and any result
// is written into a one-entry result register, which the result channel
// shows on the following cycle. A byte transfer is taken whenever the result
// register is empty or is being emptied in the same cycle, so a steady
// stream runs at one byte per cycle; only a stalled result sink with a
// waiting result holds off the receive channel. Each segment yields its data
// bytes (positions 22 to L+4) followed by one verdict (checksum good,
// checksum mismatch, or bad length given at byte 5), and bytes after the
// verdict are dropped until the next start of transfer. The segments per
// frame register may only be written while the core is idle; it resets to
// six, zero behaves as one, and values above MAX_SEGMENTS behave as
// MAX_SEGMENTS.
// ----------------------------------------------------------------------------
module radar_segment_deframer_core
    import rsd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int unsigned MAX_SEGMENTS    = DEF_MAX_SEGMENTS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [SPF_W-1:0] cfg_wr_data,
    rsd_rx_if.sink           rx_chan,
    rsd_result_if.source     result_chan
);

    logic [SPF_W-1:0] spf_reg;
    logic             accept;
    logic             emit;
    logic             out_full;
    result_t          result;

    // Segments per frame register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spf_reg <= SPF_RESET;
        end
        else if (cfg_wr_en)
        begin
            spf_reg <= cfg_wr_data;
        end
    end

    // A byte is taken when the result register has room for whatever the
    // byte may produce, counting the slot freed by a result transfer now.
    assign rx_chan.ready = !out_full || result_chan.ready;
    assign accept        = rx_chan.valid && rx_chan.ready;

    rsd_tracker #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .MAX_SEGMENTS    (MAX_SEGMENTS)
    ) u_tracker (
        .clk                (clk),
        .rst_n              (rst_n),
        .accept             (accept),
        .rx_byte            (rx_chan.rx_byte),
        .start_of_transfer  (rx_chan.start_of_transfer),
        .resync             (rx_chan.resync),
        .segments_per_frame (spf_reg),
        .emit               (emit),
        .result             (result)
    );

    // Results are loaded only for accepted bytes that produce one.
    rsd_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept && emit),
        .result (result),
        .full   (out_full),
        .res    (result_chan)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radar segment deframer core testbench
// Sends segmented sensor transfers, malformed frames and noise through the
// deframer under changing flow control and segment counts, predicts every
// data byte and verdict alongside, and checks each result as it leaves.
// ----------------------------------------------------------------------------
module testbench
    import rsd_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 240;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              sot;
        logic              rsy;
    } rx_byte_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [SPF_W-1:0] cfg_wr_data = '0;

    rsd_rx_if     rx_bus ();
    rsd_result_if result_bus ();

    radar_segment_deframer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_chan     (rx_bus),
        .result_chan (result_bus)
    );

    // The clock runs from time zero; every edge of the bench follows from it.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    rx_byte_t   rx_backlog[$];       // bytes waiting to be offered
    result_t    deframed_due[$];     // data bytes and verdicts still to arrive
    rx_byte_t   next_byte;
    int unsigned bytes_queued  = 0;
    int          errors        = 0;
    int          cycles        = 0;
    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    bit          byte_taken    = 1'b0;
    bit          hold_go       = 1'b0;
    bit          sink_hold     = 1'b0;

    // Shadow of the deframer's own state, updated on every accepted byte.
    logic [POS_W-1:0]  seg_pos      = '0;
    logic [31:0]       seg_len      = '0;
    logic [BYTE_W-1:0] seg_sum      = '0;
    logic [SEG_W-1:0]  seg_idx      = '0;
    logic [REQ_W-1:0]  ack_req      = REQ_FIRST;
    bit                verdict_sent = 1'b0;
    logic [SPF_W-1:0]  frame_segs   = SPF_RESET;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------

    // The register is clamped: zero behaves as one segment per frame, and
    // anything above the segment limit behaves as the limit.
    function automatic int unsigned segs_in_frame();
        if (frame_segs == '0)
            return 1;
        if (frame_segs > DEF_MAX_SEGMENTS)
            return DEF_MAX_SEGMENTS;
        return frame_segs;
    endfunction

    // The segment index and request number are those in force before any
    // advance that the result itself causes.
    function automatic result_t make_result(input kind_t k, input logic [BYTE_W-1:0] d,
                                            input logic [OFFSET_W-1:0] off,
                                            input status_t st, input logic done);
        result_t r;
        r.kind             = k;
        r.data_byte        = d;
        r.segment          = seg_idx;
        r.data_offset      = off;
        r.status           = st;
        r.frame_done       = done;
        r.next_ack_request = ack_req;
        return r;
    endfunction

    // Works out what one accepted byte does to the segment and queues the
    // data byte or verdict that it causes, if any.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic sot,
                                input logic rsy);
        logic [POS_W-1:0] p;
        longint unsigned  last;
        int unsigned      next_idx;
        bit               done;
        if (sot)
        begin
            seg_pos      = '0;
            seg_len      = '0;
            seg_sum      = '0;
            verdict_sent = 1'b0;
            if (rsy)
            begin
                seg_idx = '0;
                ack_req = REQ_FIRST;
            end
            // Request numbers run from two up to one past the segment count.
            ack_req = ack_req + 1'b1;
            if (ack_req > segs_in_frame() + 1)
                ack_req = REQ_FIRST;
        end
        if (verdict_sent)
            return;

        p = seg_pos;
        if (seg_pos != POS_MAX)
            seg_pos = seg_pos + 1'b1;
        // The header byte is neither checked nor summed.
        if (p == 0)
            return;

        if (p <= LEN_LAST)
        begin
            if (p >= LEN_FIRST)
                seg_len = seg_len | (32'(b) << (8 * (p - LEN_FIRST)));
            seg_sum = seg_sum + b;
            last = {32'd0, seg_len} + 64'd5;
            // A length that is too short, or one that would run past the
            // buffer, ends the segment at once with a bad length verdict.
            if (p == LEN_LAST && (seg_len < MIN_LEN || last >= DEF_MAX_FRAME_BYTES))
            begin
                deframed_due.push_back(make_result(KIND_VERDICT, '0, '0,
                                                   STATUS_BAD_LENGTH, 1'b0));
                verdict_sent = 1'b1;
            end
            return;
        end

        last = {32'd0, seg_len} + 64'd5;
        if (p < last)
        begin
            seg_sum = seg_sum + b;
            if (p >= DATA_FIRST)
                deframed_due.push_back(make_result(KIND_DATA, b,
                                                   OFFSET_W'(p - DATA_FIRST),
                                                   STATUS_OK, 1'b0));
        end
        else if (p == last)
        begin
            if (b == seg_sum)
            begin
                next_idx = seg_idx + 1;
                done     = (next_idx >= segs_in_frame());
                deframed_due.push_back(make_result(KIND_VERDICT, '0, '0, STATUS_OK, done));
                seg_idx = done ? '0 : SEG_W'(next_idx);
            end
            else
            begin
                deframed_due.push_back(make_result(KIND_VERDICT, '0, '0,
                                                   STATUS_MISMATCH, 1'b0));
            end
            verdict_sent = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: a new byte is offered at the falling edge once the last
    // one has been taken, or the channel falls idle at the chosen rate.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_bus.valid             <= 1'b0;
            rx_bus.rx_byte           <= '0;
            rx_bus.start_of_transfer <= 1'b0;
            rx_bus.resync            <= 1'b0;
        end
        else if (!rx_bus.valid || byte_taken)
        begin
            if (rx_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_byte = rx_backlog.pop_front();
                rx_bus.valid             <= 1'b1;
                rx_bus.rx_byte           <= next_byte.value;
                rx_bus.start_of_transfer <= next_byte.sot;
                rx_bus.resync            <= next_byte.rsy;
            end
            else
            begin
                rx_bus.valid <= 1'b0;
            end
        end
    end

    // The result sink stalls at random, and throughout a long hold.
    always @(negedge clk)
    begin
        result_bus.ready <= rst_n && !sink_hold && ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction,
    // then tracks register writes and accepted bytes.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : track_deframer
        result_t want;
        byte_taken <= rx_bus.valid && rx_bus.ready;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (deframed_due.size() == 0)
            begin
                $error("result transfer with nothing predicted: kind %0d segment %0d",
                       result_bus.kind, result_bus.segment);
                errors++;
            end
            else
            begin
                want = deframed_due.pop_front();
                check_field("kind", want.kind, result_bus.kind);
                check_field("data_byte", want.data_byte, result_bus.data_byte);
                check_field("segment", want.segment, result_bus.segment);
                check_field("data_offset", want.data_offset, result_bus.data_offset);
                check_field("status", want.status, result_bus.status);
                check_field("frame_done", want.frame_done, result_bus.frame_done);
                check_field("next_ack_request", want.next_ack_request,
                            result_bus.next_ack_request);
            end
        end
        if (rst_n && cfg_wr_en)
            frame_segs = cfg_wr_data;
        if (rst_n && rx_bus.valid && rx_bus.ready)
            deframe_byte(rx_bus.rx_byte, rx_bus.start_of_transfer, rx_bus.resync);
    end

    // A hung run is stopped here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The long hold on the result side is timed in its own process so that
    // the sender keeps offering bytes while the core fills and backs up.
    initial
    begin
        wait (hold_go);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [BYTE_W-1:0] value, input logic sot,
                              input logic rsy);
        rx_byte_t item;
        item.value = value;
        item.sot   = sot;
        item.rsy   = rsy;
        rx_backlog.push_back(item);
        bytes_queued++;
    endtask

    // Queues one segment of length len, cut after keep bytes. A bad length
    // only ever gets its first six bytes, as the core stops reading there.
    task automatic queue_segment(input logic [31:0] len, input bit sum_ok, input bit rsy,
                                 input int unsigned keep);
        longint unsigned   last;
        int unsigned       total;
        int unsigned       p;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] value;
        last  = {32'd0, len} + 64'd5;
        total = (len < MIN_LEN || last >= DEF_MAX_FRAME_BYTES) ? 6 : 32'(last + 64'd1);
        if (keep < total)
            total = keep;
        sum = '0;
        for (p = 0; p < total; p++)
        begin
            if (p >= LEN_FIRST && p <= LEN_LAST)
                value = len[8 * (p - LEN_FIRST) +: 8];
            else if (p == last)
                value = sum_ok ? sum : sum ^ 8'($urandom_range(1, 255));
            else
                value = 8'($urandom);
            if (p != 0 && p < last)
                sum = sum + value;
            queue_byte(value, p == 0, (p == 0) && rsy);
        end
    endtask

    // Mostly well-formed segments with random contents; the rest are cut
    // short, carry a bad length or are plain noise.
    task automatic queue_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        logic [31:0] len;
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(51, 300) : $urandom_range(17, 50);
                queue_segment(len, $urandom_range(99) < 85, $urandom_range(9) == 0, '1);
                repeat ($urandom_range(2))
                    queue_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            else if (pick < 80)
            begin
                len = $urandom_range(17, 60);
                queue_segment(len, 1'b1, 1'($urandom), $urandom_range(1, len + 5));
            end
            else if (pick < 90)
            begin
                case ($urandom_range(2))
                    0: len = $urandom_range(0, MIN_LEN - 1);
                    1: len = $urandom_range(DEF_MAX_FRAME_BYTES - 5, 20000);
                    default: len = $urandom | 32'h0001_0000;
                endcase
                queue_segment(len, 1'b1, 1'($urandom), 6);
                repeat ($urandom_range(2))
                    queue_byte(8'($urandom), 1'b0, 1'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    queue_byte(8'($urandom), $urandom_range(7) == 0, 1'($urandom));
            end
        end
    endtask

    // Waits until every byte is in and every result is out, then lets the core settle.
    task automatic wait_deframer_idle();
        while (rx_backlog.size() != 0 || rx_bus.valid || deframed_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_segs_per_frame(input logic [SPF_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Each phase starts from a quiet core, which also makes the sender wait
    // for every outstanding result before the register changes.
    task automatic run_phase(input logic [SPF_W-1:0] segs, input int src_pct,
                             input int snk_pct);
        wait_deframer_idle();
        write_segs_per_frame(segs);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        queue_random_traffic(PHASE_BYTES);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Bytes before the first start belong to a transfer begun at reset;
        // a resync without a start is ignored.
        queue_byte(8'h00, 1'b0, 1'b0);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(8'h5A, 1'b0, 1'b0);
        // A length just below the minimum, then a byte after the verdict.
        queue_segment(MIN_LEN - 1, 1'b1, 1'b0, 6);
        queue_byte(8'hA5, 1'b0, 1'b1);
        // The largest length, with a resync, and the first length that
        // would overrun the buffer.
        queue_segment(32'hFFFF_FFFF, 1'b1, 1'b1, 6);
        queue_segment(DEF_MAX_FRAME_BYTES - 5, 1'b1, 1'b0, 6);

        // No idling first, then a mostly idle source, a mostly stalled sink, and both at a low rate.
        run_phase(4'd1, 0, 0);
        run_phase(4'd8, 84, 0);
        run_phase(4'd0, 0, 84);
        run_phase(4'd15, 15, 15);

        // The result side holds off while bytes keep coming, so the core
        // fills up and stops taking bytes.
        wait_deframer_idle();
        write_segs_per_frame(4'd3);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_go       = 1'b1;
        queue_random_traffic(PHASE_BYTES);

        run_phase(4'd5, 15, 15);
        wait_deframer_idle();
        repeat (8) @(posedge clk);

        if (deframed_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", deframed_due.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* radar_segment_deframer_core.f */
design/rsd_pkg.sv
design/rsd_if.sv
design/rsd_tracker.sv
design/rsd_out_stage.sv
design/radar_segment_deframer_core.sv
bench/testbench.sv
